// File: rtl/ssr_pkg.sv
package ssr_pkg;

    // Longest pattern or replacement, in bytes.
    localparam int MAX_LEN = 8;
    localparam int BYTE_W  = 8;
    localparam int TEXT_W  = MAX_LEN * BYTE_W;
    // Width of a length register as written through the configuration port.
    localparam int LEN_W   = 4;
    // Count of held bytes, 0 to MAX_LEN inclusive.
    localparam int CNT_W   = $clog2(MAX_LEN + 1);
    // Index of one byte within a pattern or replacement.
    localparam int IDX_W   = $clog2(MAX_LEN);
    localparam int CFG_IDX_W = 2;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_MATCH_TEXT     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MATCH_LENGTH   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_REPLACE_TEXT   = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_REPLACE_LENGTH = 2'd3;

    // Input kinds carried on the slave-side tuser.
    localparam logic OP_TEXT = 1'b0;
    localparam logic OP_EOL  = 1'b1;

    // Per-cell control: shift moves every byte one cell towards the head,
    // load captures the incoming text byte into the first free cell.
    typedef struct packed {
        logic shift;
        logic load;
    } cell_ctrl_t;

    // Bring a length register into range; the pattern length never drops below one.
    function automatic logic [CNT_W-1:0] clamp_len(input logic [LEN_W-1:0] value,
                                                   input logic            allow_zero);
        logic [CNT_W-1:0] result;
        if ((value == '0) && !allow_zero) begin
            result = CNT_W'(1);
        end else if (32'(value) > MAX_LEN) begin
            result = CNT_W'(MAX_LEN);
        end else begin
            result = CNT_W'(value);
        end
        return result;
    endfunction

endpackage

// File: rtl/stream_substring_replace.sv
// Streaming find-and-replace over a text line, one byte per input transaction.
// Slave side: s_tdata carries a text byte, s_tuser selects a text byte (0) or
// an end of line (1). Master side: m_tdata carries an output byte, m_tuser is
// set for a text byte and clear for the end marker, m_tlast marks the end marker.
// Every leftmost, non-overlapping occurrence of the pattern is replaced; bytes
// that may still start a match are held back in a row of byte cells.
// The configuration port writes the pattern, its length, the replacement and
// its length, one register per write; writing the pattern or its length drops held bytes.
// Timing: a byte is taken in the idle state and its window is checked in the next.
// Bytes released from the head of the cell row, replacement bytes and the end
// marker are each produced one per cycle by the controller while the output
// register is free. Each output is registered and appears in the cycle after
// the controller produces it. Reset empties the cell row and the output register,
// returns the controller to idle, restores the pattern length to one and clears
// the pattern, the replacement and its length. When the receiver stalls the
// output register holds its transaction and a state that must emit an output
// waits; s_tready is high only in the idle state.
module stream_substring_replace (
    input  logic                          aclk,
    input  logic                          aresetn,
    // Configuration write port.
    input  logic                          cfg_wr_en,
    input  logic [ssr_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [ssr_pkg::TEXT_W-1:0]    cfg_wdata,
    // Input stream.
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [7:0]                    s_tdata,   // text_byte
    input  logic                          s_tuser,   // operation
    // Output stream.
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [7:0]                    m_tdata,   // out_byte
    output logic                          m_tuser,   // carries_byte
    output logic                          m_tlast    // line_done
);
    import ssr_pkg::*;

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_SCAN  = 4'b0010,
        ST_REPL  = 4'b0100,
        ST_FLUSH = 4'b1000
    } state_t;

    state_t state_reg, state_next;

    logic [TEXT_W-1:0] match_text_reg, match_text_next;
    logic [LEN_W-1:0]  match_length_reg, match_length_next;
    logic [TEXT_W-1:0] replace_text_reg, replace_text_next;
    logic [LEN_W-1:0]  replace_length_reg, replace_length_next;

    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [CNT_W-1:0]  ridx_reg, ridx_next;

    logic              m_tvalid_reg, m_tvalid_next;
    logic [BYTE_W-1:0] m_tdata_reg, m_tdata_next;
    logic              m_tuser_reg, m_tuser_next;
    logic              m_tlast_reg, m_tlast_next;

    logic [CNT_W-1:0]  mlen;
    logic [CNT_W-1:0]  rlen;
    logic              out_free;
    logic              accept;
    logic              shift;
    logic              all_hit;
    logic              is_prefix;

    cell_ctrl_t        cell_ctrl [MAX_LEN];
    logic [BYTE_W-1:0] held [MAX_LEN];
    logic [BYTE_W-1:0] repl_bytes [MAX_LEN];
    logic [MAX_LEN-1:0] hit;
    logic [MAX_LEN-1:0] valid;

    assign mlen     = clamp_len(match_length_reg, 1'b0);
    assign rlen     = clamp_len(replace_length_reg, 1'b1);
    assign out_free = !m_tvalid_reg || m_tready;
    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;

    // Row of byte cells; the head cell holds the oldest byte.
    for (genvar i = 0; i < MAX_LEN; i++) begin : g_cell
        logic [BYTE_W-1:0] from_next;

        if (i == MAX_LEN - 1) begin : g_tail
            assign from_next = '0;
        end else begin : g_link
            assign from_next = held[i+1];
        end

        assign cell_ctrl[i].shift = shift;
        assign cell_ctrl[i].load  = accept && (s_tuser == OP_TEXT) && (cnt_reg == CNT_W'(i));
        assign valid[i]           = (CNT_W'(i) < cnt_reg);
        assign repl_bytes[i]      = replace_text_reg[i*BYTE_W +: BYTE_W];

        ssr_cell u_cell (
            .aclk         (aclk),
            .ctrl         (cell_ctrl[i]),
            .new_byte     (s_tdata),
            .next_byte    (from_next),
            .pattern_byte (match_text_reg[i*BYTE_W +: BYTE_W]),
            .held_byte    (held[i]),
            .hit          (hit[i])
        );
    end

    // The held window is a prefix when every occupied cell matches and it is not too long.
    assign all_hit   = &(hit | ~valid);
    assign is_prefix = all_hit && (cnt_reg <= mlen);

    // Controller: take a byte, release bytes until the window is a prefix,
    // then emit the replacement on a full match; end of line drains the row.
    always_comb begin
        state_next          = state_reg;
        cnt_next            = cnt_reg;
        ridx_next           = ridx_reg;
        shift               = 1'b0;
        match_text_next     = match_text_reg;
        match_length_next   = match_length_reg;
        replace_text_next   = replace_text_reg;
        replace_length_next = replace_length_reg;
        m_tvalid_next       = m_tvalid_reg && !m_tready;
        m_tdata_next        = m_tdata_reg;
        m_tuser_next        = m_tuser_reg;
        m_tlast_next        = m_tlast_reg;

        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    if (s_tuser == OP_EOL) begin
                        state_next = ST_FLUSH;
                    end else begin
                        cnt_next   = cnt_reg + CNT_W'(1);
                        state_next = ST_SCAN;
                    end
                end
            end
            ST_SCAN: begin
                if (is_prefix) begin
                    if (cnt_reg == mlen) begin
                        cnt_next   = '0;
                        ridx_next  = '0;
                        state_next = (rlen != '0) ? ST_REPL : ST_IDLE;
                    end else begin
                        state_next = ST_IDLE;
                    end
                end else if (out_free) begin
                    // Release the oldest byte and test the shorter window next cycle.
                    shift         = 1'b1;
                    cnt_next      = cnt_reg - CNT_W'(1);
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = held[0];
                    m_tuser_next  = 1'b1;
                    m_tlast_next  = 1'b0;
                end
            end
            ST_REPL: begin
                if (out_free) begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = repl_bytes[ridx_reg[IDX_W-1:0]];
                    m_tuser_next  = 1'b1;
                    m_tlast_next  = 1'b0;
                    ridx_next     = ridx_reg + CNT_W'(1);
                    if (ridx_next == rlen) begin
                        state_next = ST_IDLE;
                    end
                end
            end
            ST_FLUSH: begin
                if (out_free) begin
                    m_tvalid_next = 1'b1;
                    if (cnt_reg != '0) begin
                        shift        = 1'b1;
                        cnt_next     = cnt_reg - CNT_W'(1);
                        m_tdata_next = held[0];
                        m_tuser_next = 1'b1;
                        m_tlast_next = 1'b0;
                    end else begin
                        m_tdata_next = '0;
                        m_tuser_next = 1'b0;
                        m_tlast_next = 1'b1;
                        state_next   = ST_IDLE;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
                cnt_next   = '0;
            end
        endcase

        // Register writes; a new pattern invalidates the held bytes.
        if (cfg_wr_en) begin
            case (cfg_index)
                CFG_MATCH_TEXT: begin
                    match_text_next = cfg_wdata;
                    cnt_next        = '0;
                end
                CFG_MATCH_LENGTH: begin
                    match_length_next = cfg_wdata[LEN_W-1:0];
                    cnt_next          = '0;
                end
                CFG_REPLACE_TEXT: begin
                    replace_text_next = cfg_wdata;
                end
                CFG_REPLACE_LENGTH: begin
                    replace_length_next = cfg_wdata[LEN_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    // Control and configuration registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg          <= ST_IDLE;
            cnt_reg            <= '0;
            ridx_reg           <= '0;
            m_tvalid_reg       <= 1'b0;
            match_text_reg     <= '0;
            match_length_reg   <= LEN_W'(1);
            replace_text_reg   <= '0;
            replace_length_reg <= '0;
        end else begin
            state_reg          <= state_next;
            cnt_reg            <= cnt_next;
            ridx_reg           <= ridx_next;
            m_tvalid_reg       <= m_tvalid_next;
            match_text_reg     <= match_text_next;
            match_length_reg   <= match_length_next;
            replace_text_reg   <= replace_text_next;
            replace_length_reg <= replace_length_next;
        end
    end

    // Output payload register.
    always_ff @(posedge aclk) begin
        m_tdata_reg <= m_tdata_next;
        m_tuser_reg <= m_tuser_next;
        m_tlast_reg <= m_tlast_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;
    assign m_tlast  = m_tlast_reg;

endmodule

// File: rtl/ssr_cell.sv
module ssr_cell (
    input  logic                       aclk,
    input  ssr_pkg::cell_ctrl_t        ctrl,
    input  logic [ssr_pkg::BYTE_W-1:0] new_byte,
    input  logic [ssr_pkg::BYTE_W-1:0] next_byte,
    input  logic [ssr_pkg::BYTE_W-1:0] pattern_byte,
    output logic [ssr_pkg::BYTE_W-1:0] held_byte,
    output logic                       hit
);
    import ssr_pkg::*;

    logic [BYTE_W-1:0] byte_reg;
    logic [BYTE_W-1:0] byte_next;

    // A shift takes the neighbour's byte; otherwise a load takes the new text byte.
    always_comb begin
        byte_next = byte_reg;
        if (ctrl.shift) begin
            byte_next = next_byte;
        end else if (ctrl.load) begin
            byte_next = new_byte;
        end
    end

    always_ff @(posedge aclk) begin
        byte_reg <= byte_next;
    end

    // Each cell compares its byte against the pattern byte at the same position.
    assign held_byte = byte_reg;
    assign hit       = (byte_reg == pattern_byte);

endmodule

// File: verif/tb_top.sv
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import ssr_pkg::*;

    // Cycles without any transaction before the run is declared hung.
    localparam int QUIET_LIMIT  = 4000;
    // Cycles allowed for the block to finish internal work once nothing is awaited.
    localparam int SETTLE       = 12;
    localparam int PHASES       = 7;
    localparam int PHASE_ITEMS  = 36;
    localparam int IDLE_PERCENT = 30;

    // One output transaction as the checker sees it.
    typedef struct packed {
        logic [7:0] octet;
        logic       carries;
        logic       done;
    } text_result_t;

    // Tracks the held bytes and registers of the block and the outputs still owed.
    class replace_checker;
        logic [TEXT_W-1:0] match_txt;
        logic [TEXT_W-1:0] repl_txt;
        logic [LEN_W-1:0]  match_len;
        logic [LEN_W-1:0]  repl_len;
        logic [7:0]        held [MAX_LEN];
        int                held_cnt;
        text_result_t      awaited [$];
        int                checked;
        int                mismatches;
        int                replacements;

        function new();
            match_txt    = '0;
            repl_txt     = '0;
            match_len    = LEN_W'(1);
            repl_len     = '0;
            held_cnt     = 0;
            checked      = 0;
            mismatches   = 0;
            replacements = 0;
        endfunction

        // Lengths outside the legal range saturate; the pattern is never empty.
        function int bounded(logic [LEN_W-1:0] v, int floor_len);
            int n;
            n = int'(v);
            if (n < floor_len) n = floor_len;
            if (n > MAX_LEN) n = MAX_LEN;
            return n;
        endfunction

        function void owe(logic [7:0] octet, logic carries, logic done);
            text_result_t r;
            r.octet   = octet;
            r.carries = carries;
            r.done    = done;
            awaited.push_back(r);
        endfunction

        // A new pattern invalidates whatever bytes were held against the old one.
        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [TEXT_W-1:0] val);
            case (idx)
                CFG_MATCH_TEXT: begin
                    match_txt = val;
                    held_cnt  = 0;
                end
                CFG_MATCH_LENGTH: begin
                    match_len = val[LEN_W-1:0];
                    held_cnt  = 0;
                end
                CFG_REPLACE_TEXT: begin
                    repl_txt = val;
                end
                default: begin
                    repl_len = val[LEN_W-1:0];
                end
            endcase
        endfunction

        // Work out the outputs caused by one accepted input transaction.
        function void take_input(logic op, logic [7:0] octet);
            logic [7:0] cand [MAX_LEN];
            int         len;
            int         start;
            int         mlen;
            int         rlen;
            bit         prefix;
            bit         settled;
            mlen = bounded(match_len, 1);
            if (op == OP_EOL) begin
                for (int i = 0; i < held_cnt; i++) owe(held[i], 1'b1, 1'b0);
                held_cnt = 0;
                owe(8'h00, 1'b0, 1'b1);
                return;
            end
            for (int i = 0; i < held_cnt; i++) cand[i] = held[i];
            cand[held_cnt] = octet;
            len = held_cnt + 1;
            // Release the oldest byte until the remainder is a prefix of the pattern.
            start   = 0;
            settled = 1'b0;
            while (start < len && !settled) begin
                prefix = (len - start) <= mlen;
                for (int i = start; i < len; i++)
                    if (prefix && cand[i] != match_txt[8*(i-start) +: 8]) prefix = 1'b0;
                if (prefix) begin
                    settled = 1'b1;
                end else begin
                    owe(cand[start], 1'b1, 1'b0);
                    start++;
                end
            end
            // A full match is swapped for the replacement, possibly nothing at all.
            if (start < len && len - start == mlen) begin
                rlen = bounded(repl_len, 0);
                for (int i = 0; i < rlen; i++) owe(repl_txt[8*i +: 8], 1'b1, 1'b0);
                held_cnt = 0;
                replacements++;
            end else begin
                held_cnt = len - start;
                for (int i = 0; i < held_cnt; i++) held[i] = cand[start + i];
            end
        endfunction

        function void check_output(logic [7:0] octet, logic carries, logic done);
            text_result_t want;
            checked++;
            if (awaited.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("[%0t] unexpected output: byte %h carries %b done %b",
                             $realtime, octet, carries, done);
                return;
            end
            want = awaited.pop_front();
            if (want.octet !== octet || want.carries !== carries || want.done !== done) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("[%0t] output %0d: expected byte %h carries %b done %b, got %h %b %b",
                             $realtime, checked, want.octet, want.carries, want.done,
                             octet, carries, done);
            end
        endfunction

        function int outstanding();
            return awaited.size();
        endfunction
    endclass

    logic                 aclk;
    logic                 aresetn;
    logic                 cfg_wr_en;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [TEXT_W-1:0]    cfg_wdata;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [7:0]           s_tdata;   // text_byte
    logic                 s_tuser;   // operation
    logic                 m_tvalid;
    logic                 m_tready;
    logic [7:0]           m_tdata;   // out_byte
    logic                 m_tuser;   // carries_byte
    logic                 m_tlast;   // line_done

    replace_checker board = new();
    bit             idle_on;
    int             items_sent;
    int             lines_ended;
    int             configs_applied;
    int             quiet_cycles;

    stream_substring_replace dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    // The receiver stalls at random while idling is enabled.
    initial begin
        m_tready = 1'b0;
        forever begin
            @(negedge aclk);
            m_tready <= !(idle_on && $urandom_range(0, 99) < IDLE_PERCENT);
        end
    end

    // Every accepted output transaction is checked against the oldest one owed.
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready)
            board.check_output(m_tdata, m_tuser, m_tlast);
    end

    // Watchdog: too long without any transaction means the block has hung.
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet_cycles = 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("[%0t] no transaction for %0d cycles", $realtime, QUIET_LIMIT);
            $display("FAILURE");
            $finish;
        end else begin
            quiet_cycles++;
        end
    end

    // Offer one input transaction, with random gaps, and record it on acceptance.
    task automatic send_item(input logic op, input logic [7:0] octet);
        while (idle_on && $urandom_range(0, 99) < IDLE_PERCENT) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= octet;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        board.take_input(op, octet);
        items_sent++;
        if (op == OP_EOL) lines_ended++;
        @(negedge aclk);
    endtask

    // Hold off the sender until every owed output has arrived and the block is quiet.
    task automatic drain();
        s_tvalid <= 1'b0;
        while (board.outstanding() != 0) @(negedge aclk);
        repeat (SETTLE) @(negedge aclk);
    endtask

    task automatic write_one(input logic [CFG_IDX_W-1:0] idx, input logic [TEXT_W-1:0] val);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        board.write_reg(idx, val);
        @(negedge aclk);
    endtask

    // Write the registers selected by the mask, one per cycle, while the block is idle.
    task automatic set_config(input logic [3:0] mask, input logic [TEXT_W-1:0] mt,
                              input logic [LEN_W-1:0] ml, input logic [TEXT_W-1:0] rt,
                              input logic [LEN_W-1:0] rl);
        if (mask[CFG_MATCH_TEXT])     write_one(CFG_MATCH_TEXT, mt);
        if (mask[CFG_MATCH_LENGTH])   write_one(CFG_MATCH_LENGTH, TEXT_W'(ml));
        if (mask[CFG_REPLACE_TEXT])   write_one(CFG_REPLACE_TEXT, rt);
        if (mask[CFG_REPLACE_LENGTH]) write_one(CFG_REPLACE_LENGTH, TEXT_W'(rl));
        cfg_wr_en <= 1'b0;
        configs_applied++;
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++) send_item(OP_TEXT, s[i]);
    endtask

    function automatic logic [TEXT_W-1:0] random_word();
        return {$urandom(), $urandom()};
    endfunction

    // Pattern bytes drawn mostly from two letters, so that self-overlap is common.
    function automatic logic [TEXT_W-1:0] random_pattern();
        logic [TEXT_W-1:0] w;
        for (int i = 0; i < MAX_LEN; i++)
            w[8*i +: 8] = ($urandom_range(0, 99) < 70) ? (8'h61 + 8'($urandom_range(0, 1)))
                                                       : 8'($urandom_range(0, 255));
        return w;
    endfunction

    // Whole or broken occurrences of the pattern, single pattern bytes, noise and line ends.
    task automatic random_phase(input int count, input logic [TEXT_W-1:0] mt,
                                input logic [LEN_W-1:0] ml);
        int plen;
        int sent;
        int r;
        int spoil;
        plen = (ml == '0) ? 1 : ((int'(ml) > MAX_LEN) ? MAX_LEN : int'(ml));
        sent = 0;
        while (sent < count) begin
            r = $urandom_range(0, 99);
            if (r < 7) begin
                send_item(OP_EOL, 8'($urandom_range(0, 255)));
                sent++;
            end else if (r < 40) begin
                spoil = ($urandom_range(0, 3) == 0) ? $urandom_range(0, plen - 1) : -1;
                for (int i = 0; i < plen; i++) begin
                    if (i == spoil) send_item(OP_TEXT, 8'($urandom_range(0, 255)));
                    else send_item(OP_TEXT, mt[8*i +: 8]);
                    sent++;
                end
            end else if (r < 75) begin
                send_item(OP_TEXT, mt[8*$urandom_range(0, plen - 1) +: 8]);
                sent++;
            end else begin
                send_item(OP_TEXT, 8'($urandom_range(0, 255)));
                sent++;
            end
        end
    endtask

    initial begin
        logic [TEXT_W-1:0] mt;
        logic [TEXT_W-1:0] rt;
        logic [LEN_W-1:0]  ml;
        logic [LEN_W-1:0]  rl;
        logic [3:0]        mask;

        aresetn         = 1'b0;
        cfg_wr_en       = 1'b0;
        cfg_index       = '0;
        cfg_wdata       = '0;
        s_tvalid        = 1'b0;
        s_tdata         = '0;
        s_tuser         = OP_TEXT;
        idle_on         = 1'b1;
        items_sent      = 0;
        lines_ended     = 0;
        configs_applied = 0;
        quiet_cycles    = 0;
        repeat (11) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Reset registers: a one-byte pattern of zero with an empty replacement deletes zeros.
        send_item(OP_TEXT, 8'h00);
        send_item(OP_TEXT, 8'hFF);
        send_item(OP_EOL, 8'hA5);
        drain();

        // Overlapping three-byte pattern, partial matches released, line end after the last match.
        set_config(4'hF, TEXT_W'("aba"), LEN_W'(3), TEXT_W'("ZYX"), LEN_W'(2));
        send_text("ababaaba");
        send_item(OP_EOL, 8'h00);
        drain();

        // Zero pattern length acts as one; an oversized replacement length acts as the maximum.
        set_config(4'hF, TEXT_W'("q"), LEN_W'(0), {TEXT_W{1'b1}}, LEN_W'(15));
        send_item(OP_TEXT, "q");
        send_item(OP_EOL, 8'hFF);
        drain();

        // Oversized pattern length acts as the maximum; a match is deleted outright.
        set_config(4'hF, TEXT_W'("hgfedcba"), LEN_W'(15), '0, LEN_W'(0));
        send_text("abcdefgh");
        // A new pattern mid-line drops the bytes held so far.
        send_text("ab");
        drain();
        set_config(4'b0001, TEXT_W'("xyz"), '0, '0, '0);
        send_item(OP_EOL, 8'h3C);
        drain();

        // Random phases, each with its own register setting, the extremes first.
        for (int p = 0; p < PHASES; p++) begin
            mt   = random_pattern();
            rt   = random_word();
            ml   = LEN_W'($urandom_range(1, MAX_LEN));
            rl   = LEN_W'($urandom_range(0, MAX_LEN));
            mask = ($urandom_range(0, 1) == 0) ? 4'hF : 4'($urandom_range(0, 15));
            case (p)
                0: begin
                    ml   = LEN_W'(MAX_LEN);
                    rl   = LEN_W'(MAX_LEN);
                    mask = 4'hF;
                end
                1: begin
                    ml   = LEN_W'(1);
                    rl   = '0;
                    mask = 4'hF;
                end
                3: begin
                    ml = ($urandom_range(0, 1) == 0) ? LEN_W'(0) : {LEN_W{1'b1}};
                    rl = {LEN_W{1'b1}};
                    mt = ($urandom_range(0, 1) == 0) ? {TEXT_W{1'b1}} : random_word();
                end
                default: begin
                end
            endcase
            // Registers left unwritten keep their values, so follow what the block holds.
            if (!mask[CFG_MATCH_TEXT])   mt = board.match_txt;
            if (!mask[CFG_MATCH_LENGTH]) ml = board.match_len;
            set_config(mask, mt, ml, rt, rl);
            // One phase runs with both sides at full rate.
            idle_on = (p != 2);
            random_phase(PHASE_ITEMS, mt, ml);
            drain();
            idle_on = 1'b1;
        end

        $display("Sent %0d input transactions including %0d line ends, checked %0d outputs.",
                 items_sent, lines_ended, board.checked);
        $display("Applied %0d register settings, saw %0d pattern replacements, %0d mismatches.",
                 configs_applied, board.replacements, board.mismatches);
        if (board.mismatches == 0 && board.outstanding() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
